FILE: hdl/ecp_pkg.sv
// Shared constants, codes and the result record of the host command port engine.
package ecp_pkg;

    // Largest payload held for one command
    localparam int ECP_MAX_PAYLOAD = 256;

    // Configuration reset values
    localparam logic [19:0] POLL_LIMIT_RST = 20'd1000000;
    localparam logic [7:0]  DATA_PORT_RST  = 8'h62;
    localparam logic [7:0]  CMD_PORT_RST   = 8'h66;

    // Protocol bytes
    localparam logic [7:0]  MAGIC_BYTE = 8'hDA;
    localparam logic [7:0]  STRUCT_VER = 8'h03;
    localparam logic [15:0] HDR_LEN    = 16'd8;

    // Input item modes
    localparam logic [1:0] MODE_START   = 2'd0;
    localparam logic [1:0] MODE_PAYLOAD = 2'd1;
    localparam logic [1:0] MODE_DONE    = 2'd2;

    // Command outcomes
    localparam logic [1:0] OUTCOME_OK       = 2'd0;
    localparam logic [1:0] OUTCOME_TIMEOUT  = 2'd1;
    localparam logic [1:0] OUTCOME_EC_ERROR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_POLL_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DATA_PORT  = 2'd1;
    localparam logic [1:0] CFG_CMD_PORT   = 2'd2;

    // One result item
    typedef struct packed {
        logic        access_valid;
        logic        access_write;
        logic [7:0]  access_port;
        logic [7:0]  access_data;
        logic        rx_valid;
        logic [7:0]  rx_byte;
        logic        done_res;
        logic [1:0]  outcome;
        logic [15:0] ec_result;
        logic [15:0] bytes_read;
    } t_result;

endpackage

FILE: hdl/ecp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ecp_seq.sv
// Command sequencer: phase control, payload buffer, header build and response parse.
module ecp_seq import ecp_pkg::*; #(
    parameter int MAX_PAYLOAD = ECP_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_acc,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_command_code,
    input  logic [7:0]  i_command_version,
    input  logic [8:0]  i_payload_length,
    input  logic [15:0] i_response_capacity,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output t_result     o_res,
    output logic        o_res_valid
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LW = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_LOAD    = 7'b0000010,
        PH_WAIT_TX = 7'b0000100,
        PH_SEND    = 7'b0001000,
        PH_WAIT_RX = 7'b0010000,
        PH_HEADER  = 7'b0100000,
        PH_DATA    = 7'b1000000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_sum, n_sum;
    logic [19:0] r_poll, n_poll;
    logic [15:0] r_cmd, n_cmd;
    logic [7:0]  r_ver, n_ver;
    logic [LW-1:0] r_len, n_len;
    logic [15:0] r_cap, n_cap;
    logic [15:0] r_res, n_res;
    logic [15:0] r_dlen, n_dlen;
    logic [15:0] r_btr, n_btr;
    logic [19:0] r_poll_limit;
    logic [7:0]  r_data_port;
    logic [7:0]  r_cmd_port;

    logic [15:0] in_len16;
    logic [15:0] len_sat;
    logic [15:0] len16;
    logic [15:0] total;
    logic [7:0]  chk;
    logic [7:0]  hdr_byte;
    logic [15:0] rd_sub;
    logic        ram_we;
    logic [7:0]  ram_rdata;
    logic        ready;
    logic        timeout;
    logic [15:0] min_len;
    t_result     res;
    logic        res_valid;

    // Saturate the requested payload length
    assign in_len16 = 16'(i_payload_length);
    assign len_sat  = (in_len16 > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD) : in_len16;
    assign len16    = 16'(r_len);
    assign total    = HDR_LEN + len16;

    // Checksum makes the 8-bit sum of header and payload zero
    assign chk = 8'd0 - (STRUCT_VER + r_cmd[7:0] + r_cmd[15:8] + r_ver
                         + len16[7:0] + len16[15:8] + r_sum);

    // Pick the request header byte at the current position
    always_comb begin
        unique case (r_pos[2:0])
            3'd0:    hdr_byte = STRUCT_VER;
            3'd1:    hdr_byte = chk;
            3'd2:    hdr_byte = r_cmd[7:0];
            3'd3:    hdr_byte = r_cmd[15:8];
            3'd4:    hdr_byte = r_ver;
            3'd5:    hdr_byte = 8'd0;
            3'd6:    hdr_byte = len16[7:0];
            default: hdr_byte = len16[15:8];
        endcase
    end

    // Status bit 0 clear means the controller is ready
    assign ready   = ~i_data_byte[0];
    assign timeout = (r_poll >= r_poll_limit);
    assign min_len = (r_dlen < r_cap) ? r_dlen : r_cap;

    // Advance the sequencer by one item
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_poll    = r_poll;
        n_cmd     = r_cmd;
        n_ver     = r_ver;
        n_len     = r_len;
        n_cap     = r_cap;
        n_res     = r_res;
        n_dlen    = r_dlen;
        n_btr     = r_btr;
        res       = '0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        if (i_acc) begin
            unique case (i_mode)
                MODE_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_cmd = i_command_code;
                        n_ver = i_command_version;
                        n_len = LW'(len_sat);
                        n_cap = i_response_capacity;
                        n_sum = 8'd0;
                        n_pos = 16'd0;
                        if (len_sat == 16'd0) begin
                            n_poll            = 20'd1;
                            n_phase           = PH_WAIT_TX;
                            res_valid         = 1'b1;
                            res.access_valid  = 1'b1;
                            res.access_port   = r_cmd_port;
                        end else begin
                            n_phase = PH_LOAD;
                        end
                    end
                end
                MODE_PAYLOAD: begin
                    if (r_phase == PH_LOAD) begin
                        ram_we = 1'b1;
                        n_sum  = r_sum + i_data_byte;
                        n_pos  = r_pos + 16'd1;
                        if (n_pos >= len16) begin
                            n_poll           = 20'd1;
                            n_phase          = PH_WAIT_TX;
                            res_valid        = 1'b1;
                            res.access_valid = 1'b1;
                            res.access_port  = r_cmd_port;
                        end
                    end
                end
                MODE_DONE: begin
                    unique case (r_phase)
                        PH_WAIT_TX, PH_WAIT_RX: begin
                            res_valid = 1'b1;
                            if (!ready) begin
                                if (timeout) begin
                                    res.done_res = 1'b1;
                                    res.outcome  = OUTCOME_TIMEOUT;
                                    n_phase      = PH_IDLE;
                                end else begin
                                    n_poll           = r_poll + 20'd1;
                                    res.access_valid = 1'b1;
                                    res.access_port  = r_cmd_port;
                                end
                            end else if (r_phase == PH_WAIT_TX) begin
                                // Controller free: send the magic byte
                                n_phase          = PH_SEND;
                                n_pos            = 16'd0;
                                res.access_valid = 1'b1;
                                res.access_write = 1'b1;
                                res.access_port  = r_cmd_port;
                                res.access_data  = MAGIC_BYTE;
                            end else begin
                                // Response ready: read the first header byte
                                n_phase          = PH_HEADER;
                                n_pos            = 16'd0;
                                res.access_valid = 1'b1;
                                res.access_port  = r_data_port;
                            end
                        end
                        PH_SEND: begin
                            res_valid        = 1'b1;
                            res.access_valid = 1'b1;
                            if (r_pos < total) begin
                                res.access_write = 1'b1;
                                res.access_port  = r_data_port;
                                res.access_data  = (r_pos < HDR_LEN) ? hdr_byte : ram_rdata;
                                n_pos            = r_pos + 16'd1;
                            end else begin
                                n_poll          = 20'd1;
                                n_phase         = PH_WAIT_RX;
                                res.access_port = r_cmd_port;
                            end
                        end
                        PH_HEADER: begin
                            res_valid = 1'b1;
                            // Keep result code and data length bytes
                            unique case (r_pos[2:0])
                                3'd2:    n_res[7:0]   = i_data_byte;
                                3'd3:    n_res[15:8]  = i_data_byte;
                                3'd4:    n_dlen[7:0]  = i_data_byte;
                                3'd5:    n_dlen[15:8] = i_data_byte;
                                default: ;
                            endcase
                            n_pos = r_pos + 16'd1;
                            if (r_pos[2:0] != 3'd7) begin
                                res.access_valid = 1'b1;
                                res.access_port  = r_data_port;
                            end else if (r_res != 16'd0) begin
                                res.done_res  = 1'b1;
                                res.outcome   = OUTCOME_EC_ERROR;
                                res.ec_result = r_res;
                                n_phase       = PH_IDLE;
                            end else begin
                                n_btr = min_len;
                                n_pos = 16'd0;
                                if (min_len == 16'd0) begin
                                    res.done_res = 1'b1;
                                    res.outcome  = OUTCOME_OK;
                                    n_phase      = PH_IDLE;
                                end else begin
                                    n_phase          = PH_DATA;
                                    res.access_valid = 1'b1;
                                    res.access_port  = r_data_port;
                                end
                            end
                        end
                        PH_DATA: begin
                            res_valid    = 1'b1;
                            res.rx_valid = 1'b1;
                            res.rx_byte  = i_data_byte;
                            n_pos        = r_pos + 16'd1;
                            if (n_pos >= r_btr) begin
                                res.done_res   = 1'b1;
                                res.outcome    = OUTCOME_OK;
                                res.bytes_read = r_btr;
                                n_phase        = PH_IDLE;
                            end else begin
                                res.access_valid = 1'b1;
                                res.access_port  = r_data_port;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Prefetch the payload byte that the next send position needs
    assign rd_sub = n_pos - HDR_LEN;

    ecp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_payload (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (rd_sub[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_pos        <= 16'd0;
            r_sum        <= 8'd0;
            r_poll       <= 20'd0;
            r_poll_limit <= POLL_LIMIT_RST;
            r_data_port  <= DATA_PORT_RST;
            r_cmd_port   <= CMD_PORT_RST;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_poll  <= n_poll;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_POLL_LIMIT: r_poll_limit <= i_cfg_data;
                    CFG_DATA_PORT:  r_data_port  <= i_cfg_data[7:0];
                    CFG_CMD_PORT:   r_cmd_port   <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Request and response fields
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_ver  <= n_ver;
        r_len  <= n_len;
        r_cap  <= n_cap;
        r_res  <= n_res;
        r_dlen <= n_dlen;
        r_btr  <= n_btr;
    end

    assign o_res       = res;
    assign o_res_valid = res_valid;

endmodule

FILE: hdl/ec_host_command_port_engine_top.sv
// Top level of the host command port engine: sequencer and two-entry result buffer.
// The engine takes one item per clock while o_in_stall is low: a start, a payload byte or
// the completion of the port access it last asked for, and each item yields at most one
// result, which is registered in the main entry, or first in the skid entry, before it
// reaches the output. Results pass through a two-entry buffer, so the input keeps taking
// items while one result waits; o_in_stall rises only when two results are waiting.
// Payload bytes go to a MAX_PAYLOAD-entry RAM whose registered read runs ahead of each send step.
module ec_host_command_port_engine_top import ecp_pkg::*; #(
    parameter int MAX_PAYLOAD = ECP_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_command_code,
    input  logic [7:0]  i_command_version,
    input  logic [8:0]  i_payload_length,
    input  logic [15:0] i_response_capacity,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_access_valid,
    output logic        o_access_write,
    output logic [7:0]  o_access_port,
    output logic [7:0]  o_access_data,
    output logic        o_rx_valid,
    output logic [7:0]  o_rx_byte,
    output logic        o_done_res,
    output logic [1:0]  o_outcome,
    output logic [15:0] o_ec_result,
    output logic [15:0] o_bytes_read
);

    logic    acc;
    logic    pop;
    logic    push;
    t_result seq_res;
    logic    seq_res_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    r_main_v, n_main_v;
    logic    r_skid_v, n_skid_v;

    // Take an item while the skid entry is free
    assign o_in_stall = r_skid_v;
    assign acc        = i_in_valid & ~r_skid_v;

    ecp_seq #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_acc               (acc),
        .i_mode              (i_mode),
        .i_command_code      (i_command_code),
        .i_command_version   (i_command_version),
        .i_payload_length    (i_payload_length),
        .i_response_capacity (i_response_capacity),
        .i_data_byte         (i_data_byte),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_res               (seq_res),
        .o_res_valid         (seq_res_valid)
    );

    assign pop  = r_main_v & ~i_out_stall;
    assign push = seq_res_valid;

    // Steer new results into the main or skid entry
    always_comb begin
        n_main   = r_main;
        n_skid   = r_skid;
        n_main_v = r_main_v;
        n_skid_v = r_skid_v;
        if (r_skid_v) begin
            if (pop) begin
                n_main   = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (push) begin
            if (!r_main_v || pop) begin
                n_main   = seq_res;
                n_main_v = 1'b1;
            end else begin
                n_skid   = seq_res;
                n_skid_v = 1'b1;
            end
        end else if (pop) begin
            n_main_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_main_v <= n_main_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_main_v;
    assign o_access_valid = r_main.access_valid;
    assign o_access_write = r_main.access_write;
    assign o_access_port  = r_main.access_port;
    assign o_access_data  = r_main.access_data;
    assign o_rx_valid     = r_main.rx_valid;
    assign o_rx_byte      = r_main.rx_byte;
    assign o_done_res     = r_main.done_res;
    assign o_outcome      = r_main.outcome;
    assign o_ec_result    = r_main.ec_result;
    assign o_bytes_read   = r_main.bytes_read;

`ifndef ASSERT_OFF
    // The skid entry only fills behind a waiting main entry
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_main_v)
        else $error("skid entry holds an item with the main entry empty");

    // The skid entry fills only when the main entry was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_main_v && i_out_stall && acc))
        else $error("skid entry filled without a stalled main entry");

    // A finished command asks for no further access
    a_done_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_access_valid)
        else $error("done result also requests a port access");

    // A delivered data byte either asks for the next one or ends the command
    a_rx_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rx_valid) |-> (o_access_valid ^ o_done_res))
        else $error("data byte neither continues nor ends the command");
`endif

endmodule
